// ===== hw/rtl/stcs_pkg.sv =====
// ----------------------------------------------------------------------------
// stcs_pkg
// Shared types and constants for the sign template color score block.
// ----------------------------------------------------------------------------
package stcs_pkg;

  localparam int unsigned SumW    = 24;
  localparam int unsigned CntW    = 17;
  localparam int unsigned ScoreW  = 17;
  localparam int unsigned LabelW  = 16;
  localparam int unsigned LabelBits = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 17;
  localparam int unsigned FracW   = 16;
  localparam int unsigned WSumW   = 20;

  localparam logic [ScoreW-1:0] OneQ16 = ScoreW'(65536);
  // floor(x / 10) == (x * RecipTen) >> RecipShift for every x below 2^20
  localparam logic [WSumW-1:0]  RecipTen   = WSumW'(838861);
  localparam int unsigned       RecipShift = 23;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_SIGN_LABEL = 2'd1,
    CFG_OUTSIDE_LIMIT = 2'd2,
    CFG_MIN_PART = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PART_RED   = 2'd0,
    PART_WHITE = 2'd1,
    PART_BLACK = 2'd2
  } part_e;

  typedef struct packed {
    logic  acc;
    logic  mul;
    logic  chk;
    logic  div_init;
    logic  div_step;
    logic  div_store;
    part_e part;
    logic  sum;
    logic  scale;
    logic  out_load;
  } stcs_cmd_t;

  typedef struct packed {
    logic reject;
  } stcs_status_t;

endpackage

// ===== hw/rtl/stcs_if.sv =====
// ----------------------------------------------------------------------------
// stcs channel interfaces
// Valid/ready channels for warped pixels and for window scores.
// ----------------------------------------------------------------------------
interface stcs_pix_if;
  logic        valid;
  logic        ready;
  logic [7:0]  tmpl_red;
  logic [7:0]  tmpl_green;
  logic [7:0]  tmpl_blue;
  logic [15:0] pixel_label;
  logic        white_hit;
  logic        black_hit;
  logic        wide_black_hit;
  logic        last_pixel;

  modport source (
    output valid, tmpl_red, tmpl_green, tmpl_blue, pixel_label,
           white_hit, black_hit, wide_black_hit, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, tmpl_red, tmpl_green, tmpl_blue, pixel_label,
           white_hit, black_hit, wide_black_hit, last_pixel,
    output ready
  );
endinterface

interface stcs_res_if;
  logic        valid;
  logic        ready;
  logic [16:0] match_score;
  logic        rejected;

  modport source (output valid, match_score, rejected, input ready);
  modport sink (input valid, match_score, rejected, output ready);
endinterface

// ===== hw/rtl/stcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// stcs_ctrl
// Window sequencer: accumulation, reject check, shared divider steps and
// result hand-off.
// ----------------------------------------------------------------------------
module stcs_ctrl
  import stcs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         in_last_i,
  output logic         in_ready_o,
  input  logic         out_ready_i,
  output logic         out_valid_o,
  input  stcs_status_t status_i,
  output stcs_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_ACC, S_MUL, S_CHK, S_DINIT, S_DSTEP, S_DSTORE, S_SUM, S_SCALE, S_OUT
  } state_e;

  state_e        state_q, state_d;
  part_e         part_q, part_d;
  logic [3:0]    cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    part_d      = part_q;
    cnt_d       = cnt_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.part  = part_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_ACC: begin
        in_ready_o = 1'b1;
        cmd_o.acc  = in_valid_i;
        if (in_valid_i && in_last_i) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_CHK;
      end
      S_CHK: begin
        cmd_o.chk = 1'b1;
        part_d    = PART_RED;
        state_d   = status_i.reject ? S_OUT : S_DINIT;
      end
      S_DINIT: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = S_DSTEP;
      end
      S_DSTEP: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          state_d = S_DSTORE;
        end
      end
      S_DSTORE: begin
        cmd_o.div_store = 1'b1;
        if (part_q == PART_BLACK) begin
          state_d = S_SUM;
        end else begin
          part_d  = part_e'(part_q + 2'd1);
          state_d = S_DINIT;
        end
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = S_OUT;
      end
      S_OUT: begin
        // wait until the output register is free or being drained
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_ACC;
        end
      end
      default: begin
        state_d = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ACC;
      part_q      <= PART_RED;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      part_q      <= part_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/stcs_dp.sv =====
// ----------------------------------------------------------------------------
// stcs_dp
// Datapath: configuration registers, per-pixel sums, reject check, shared
// bit-serial divider and final weighting.
// ----------------------------------------------------------------------------
module stcs_dp
  import stcs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic [7:0]         tmpl_red_i,
  input  logic [7:0]         tmpl_green_i,
  input  logic [7:0]         tmpl_blue_i,
  input  logic [LabelW-1:0]  pixel_label_i,
  input  logic               white_hit_i,
  input  logic               black_hit_i,
  input  logic               wide_black_hit_i,
  input  stcs_cmd_t          cmd_i,
  output stcs_status_t       status_o,
  output logic [ScoreW-1:0]  match_score_o,
  output logic               rejected_o
);

  // configuration
  logic [7:0]        thresh_q;
  logic [LabelW-1:0] sign_label_q;
  logic [10:0]       outside_limit_q;
  logic [CfgW-1:0]   min_part_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q        <= 8'd128;
      sign_label_q    <= LabelW'(1);
      outside_limit_q <= 11'd256;
      min_part_q      <= CfgW'(32768);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_THRESHOLD:     thresh_q        <= cfg_wdata_i[7:0];
        CFG_SIGN_LABEL:    sign_label_q    <= cfg_wdata_i[LabelW-1:0];
        CFG_OUTSIDE_LIMIT: outside_limit_q <= cfg_wdata_i[10:0];
        CFG_MIN_PART:      min_part_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // per-pixel classification
  logic [7:0] r, g, b, t;
  logic       is_red, outside, is_white, is_black;
  logic [8:0] gb_sum;
  logic [7:0] half, rw, mn, mx, bw, mn_rg, mx_rg;

  assign r = tmpl_red_i;
  assign g = tmpl_green_i;
  assign b = tmpl_blue_i;
  assign t = thresh_q;
  assign is_red   = pixel_label_i[LabelBits-1:0] == sign_label_q[LabelBits-1:0];
  assign outside  = (g > t) && (r < t) && (b < t);
  assign is_white = (r > t) && (g > t) && (b > t);
  assign is_black = (r < t) && (g < t) && (b < t);
  assign gb_sum   = {1'b0, g} + {1'b0, b};
  assign half     = gb_sum[8:1];
  assign rw       = (r > half) ? (r - half) : 8'd0;
  assign mn_rg    = (r < g) ? r : g;
  assign mn       = (b < mn_rg) ? b : mn_rg;
  assign mx_rg    = (r > g) ? r : g;
  assign mx       = (b > mx_rg) ? b : mx_rg;
  assign bw       = 8'd255 - mx;

  function automatic logic [SumW-1:0] sat_sum(input logic [SumW-1:0] a,
                                              input logic [7:0] v);
    logic [SumW:0] s;
    s = {1'b0, a} + (SumW+1)'(v);
    return s[SumW] ? {SumW{1'b1}} : s[SumW-1:0];
  endfunction

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] a);
    return (&a) ? a : a + CntW'(1);
  endfunction

  logic [SumW-1:0] red_w_q, red_m_q, white_w_q, white_m_q;
  logic [SumW-1:0] black_w_q, thin_m_q, thick_m_q;
  logic [CntW-1:0] out_cnt_q, out_red_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_w_q   <= '0;
      red_m_q   <= '0;
      white_w_q <= '0;
      white_m_q <= '0;
      black_w_q <= '0;
      thin_m_q  <= '0;
      thick_m_q <= '0;
      out_cnt_q <= '0;
      out_red_q <= '0;
    end else if (cmd_i.out_load) begin
      red_w_q   <= '0;
      red_m_q   <= '0;
      white_w_q <= '0;
      white_m_q <= '0;
      black_w_q <= '0;
      thin_m_q  <= '0;
      thick_m_q <= '0;
      out_cnt_q <= '0;
      out_red_q <= '0;
    end else if (cmd_i.acc) begin
      if (outside) begin
        out_cnt_q <= sat_inc(out_cnt_q);
        if (is_red) out_red_q <= sat_inc(out_red_q);
      end else begin
        red_w_q <= sat_sum(red_w_q, rw);
        if (is_red) red_m_q <= sat_sum(red_m_q, rw);
        if (is_white) begin
          white_w_q <= sat_sum(white_w_q, mn);
          if (!is_red && white_hit_i) white_m_q <= sat_sum(white_m_q, mn);
        end
        if (is_black) begin
          black_w_q <= sat_sum(black_w_q, bw);
          if (!is_red && black_hit_i) thin_m_q  <= sat_sum(thin_m_q, bw);
          if (!is_red && wide_black_hit_i) thick_m_q <= sat_sum(thick_m_q, bw);
        end
      end
    end
  end

  // outside-red check: red_count * 1024 against limit * count
  logic [CntW+10:0] rhs_q;
  logic [CntW+10:0] lhs;
  logic             rej_q;

  assign lhs = {1'b0, out_red_q, 10'd0};
  assign status_o.reject = (red_w_q == '0) || (white_w_q == '0) ||
                           (black_w_q == '0) || (lhs > rhs_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) rhs_q <= (CntW+11)'(outside_limit_q) * (CntW+11)'(out_cnt_q);
    if (cmd_i.chk) rej_q <= status_o.reject;
  end

  // shared restoring divider, one quotient bit per cycle
  logic [SumW-1:0]   div_m, div_w, black_m;
  logic [SumW-1:0]   rem_q;
  logic [FracW-1:0]  quo_q;
  logic              sat_q;
  logic [SumW:0]     rem2;
  logic [SumW:0]     rem_sub;
  logic [ScoreW-1:0] parts_q [3];

  assign black_m = (thin_m_q > thick_m_q) ? thin_m_q : thick_m_q;

  always_comb begin
    case (cmd_i.part)
      PART_RED: begin
        div_m = red_m_q;
        div_w = red_w_q;
      end
      PART_WHITE: begin
        div_m = white_m_q;
        div_w = white_w_q;
      end
      PART_BLACK: begin
        div_m = black_m;
        div_w = black_w_q;
      end
      default: begin
        div_m = red_m_q;
        div_w = red_w_q;
      end
    endcase
  end

  assign rem2    = {rem_q, 1'b0};
  assign rem_sub = rem2 - {1'b0, div_w};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      // match at or above weight gives a capped part of 1.0
      sat_q <= div_m >= div_w;
      rem_q <= div_m;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (!rem_sub[SumW]) begin
        rem_q <= rem_sub[SumW-1:0];
        quo_q <= {quo_q[FracW-2:0], 1'b1};
      end else begin
        rem_q <= rem2[SumW-1:0];
        quo_q <= {quo_q[FracW-2:0], 1'b0};
      end
    end
    if (cmd_i.div_store) begin
      parts_q[cmd_i.part] <= sat_q ? OneQ16 : {1'b0, quo_q};
    end
  end

  // weighting
  logic [ScoreW-1:0]     pr, pw, pb, pmin_rw, pmin;
  logic                  part_low;
  logic [WSumW-1:0]      wsum;
  logic [WSumW-1:0]      wsum_q;
  logic                  part_low_q;
  logic [ScoreW-1:0]     pmin_q;
  logic [2*WSumW-1:0]    prod;
  logic [ScoreW-1:0]     scaled_q;
  logic [ScoreW-1:0]     scaled_cap;

  assign pr       = parts_q[PART_RED];
  assign pw       = parts_q[PART_WHITE];
  assign pb       = parts_q[PART_BLACK];
  assign part_low = (pr < min_part_q) || (pw < min_part_q) || (pb < min_part_q);
  assign pmin_rw  = (pr < pw) ? pr : pw;
  assign pmin     = (pb < pmin_rw) ? pb : pmin_rw;
  assign wsum     = WSumW'(pr) * WSumW'(3) + WSumW'(pw) * WSumW'(3) +
                    WSumW'(pb) * WSumW'(4) + WSumW'(5);
  assign prod     = (2*WSumW)'(wsum_q) * (2*WSumW)'(RecipTen);
  assign scaled_cap = (scaled_q > OneQ16) ? OneQ16 : scaled_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      wsum_q     <= wsum;
      part_low_q <= part_low;
      pmin_q     <= pmin;
    end
    if (cmd_i.scale) begin
      scaled_q <= prod[RecipShift+ScoreW-1:RecipShift];
    end
  end

  // result register
  logic [ScoreW-1:0] score_q;
  logic              rejected_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rejected_q <= rej_q;
      score_q    <= rej_q ? '0 : (part_low_q ? pmin_q : scaled_cap);
    end
  end

  assign match_score_o = score_q;
  assign rejected_o    = rejected_q;

endmodule

// ===== hw/rtl/sign_template_color_score_core.sv =====
// ----------------------------------------------------------------------------
// sign_template_color_score_core
// Scores how well a warped scene window matches a sign color template.
// ----------------------------------------------------------------------------
// Pixels of a window are taken one per clock and summed into saturating red,
// white and black weight and match sums plus outside-pixel counts. After the
// pixel flagged last, input is held off for the scoring pass: the outside-red
// check, then an init, the quotient steps and a store for each part (red,
// white, black) on one shared divider that makes a quotient bit per cycle,
// then weight, scale and load the result before the score is offered. A
// rejected window skips the divider and goes from the check to the load.
// The next window may start while the previous score waits to be taken.
module sign_template_color_score_core
  import stcs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  stcs_pix_if.sink           pix_i,
  stcs_res_if.source         res_o
);

  stcs_cmd_t    cmd;
  stcs_status_t status;

  stcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_last_i   (pix_i.last_pixel),
    .in_ready_o  (pix_i.ready),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_o.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  stcs_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .tmpl_red_i       (pix_i.tmpl_red),
    .tmpl_green_i     (pix_i.tmpl_green),
    .tmpl_blue_i      (pix_i.tmpl_blue),
    .pixel_label_i    (pix_i.pixel_label),
    .white_hit_i      (pix_i.white_hit),
    .black_hit_i      (pix_i.black_hit),
    .wide_black_hit_i (pix_i.wide_black_hit),
    .cmd_i            (cmd),
    .status_o         (status),
    .match_score_o    (res_o.match_score),
    .rejected_o       (res_o.rejected)
  );

endmodule
